// ===== rtl/acsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acsp_pkg;

	localparam int WIDTH_BUCKETS = 6;
	localparam int WIDTH_BITS    = 10;
	localparam int FAMILY_BITS   = 2;
	localparam int TOTAL_BITS    = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 17;
	localparam int THR_BITS      = 17;

	localparam logic [WIDTH_BITS-1:0] BUCKET_LIM_0 = 10'd2;
	localparam logic [WIDTH_BITS-1:0] BUCKET_LIM_1 = 10'd4;
	localparam logic [WIDTH_BITS-1:0] BUCKET_LIM_2 = 10'd8;
	localparam logic [WIDTH_BITS-1:0] BUCKET_LIM_3 = 10'd16;
	localparam logic [WIDTH_BITS-1:0] BUCKET_LIM_4 = 10'd32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_POLICY_ENABLED = 3'd0,
		REG_WARMUP_COUNT   = 3'd1,
		REG_AUDIT_PERIOD   = 3'd2,
		REG_PRIOR_HITS     = 3'd3,
		REG_PRIOR_MISSES   = 3'd4,
		REG_MIN_POSTERIOR  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		CMD_DECIDE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                policy_enabled;
		logic [15:0]         warmup_count;
		logic [15:0]         audit_period;
		logic [15:0]         prior_hits;
		logic [15:0]         prior_misses;
		logic [THR_BITS-1:0] min_posterior;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		policy_enabled: 1'b1,
		warmup_count:   16'd8,
		audit_period:   16'd64,
		prior_hits:     16'd256,
		prior_misses:   16'd256,
		min_posterior:  17'd32768
	};

	function automatic logic [2:0] bucket_of(input logic [WIDTH_BITS-1:0] w);
		logic [2:0] b;
		b = 3'd0;
		if (w > BUCKET_LIM_0) b = 3'd1;
		if (w > BUCKET_LIM_1) b = 3'd2;
		if (w > BUCKET_LIM_2) b = 3'd3;
		if (w > BUCKET_LIM_3) b = 3'd4;
		if (w > BUCKET_LIM_4) b = 3'd5;
		return b;
	endfunction

	function automatic logic [TOTAL_BITS-1:0] sat_inc_total(input logic [TOTAL_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/acsp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acsp_req_if;
	import acsp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [FAMILY_BITS-1:0] gate_family;
	logic [WIDTH_BITS-1:0]  comp_width;
	logic                   compaction_succeeds;

	modport source (output valid, command, gate_family, comp_width,
		compaction_succeeds, input ready);
	modport sink (input valid, command, gate_family, comp_width,
		compaction_succeeds, output ready);
endinterface
`default_nettype wire

// ===== rtl/acsp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acsp_rsp_if;
	import acsp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  do_check;
	logic                  is_audit;
	logic [TOTAL_BITS-1:0] total_checks;
	logic [TOTAL_BITS-1:0] total_successes;
	logic [TOTAL_BITS-1:0] total_skips;
	logic [TOTAL_BITS-1:0] total_audits;

	modport source (output valid, do_check, is_audit, total_checks, total_successes,
		total_skips, total_audits, input ready);
	modport sink (input valid, do_check, is_audit, total_checks, total_successes,
		total_skips, total_audits, output ready);
endinterface
`default_nettype wire

// ===== rtl/acsp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acsp_cfg_if;
	import acsp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/adaptive_check_skip_policy.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Decides per request whether the costly check runs, learning per context (gate family and
// width bucket) in a context memory with a registered read. The memory is read at the edge
// that accepts a decide request, and the data then passes through the posterior unit (prior
// sums, two half-width products against the threshold, their sum, the compare); after that
// the block decides, writes the context back and registers the result once the output is
// free. A clear request or a request with a family out of range goes through a fast state
// that registers its result once the output is free. Requests are handled one at a time and
// the next one is taken in the cycle after a result is registered, so no new request is
// taken while one is in flight. A finished result waits in the output register while the
// next request is taken. Clearing drops the valid bit of every context entry at once and
// needs no sweep.
module adaptive_check_skip_policy #(
	parameter int FAMILY_COUNT = 3,
	parameter int COUNTER_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	acsp_req_if.sink    req,
	acsp_rsp_if.source  rsp,
	acsp_cfg_if.sink    cfg
);
	import acsp_pkg::*;

	localparam int CTX_COUNT = FAMILY_COUNT * WIDTH_BUCKETS;
	localparam int AW        = (CTX_COUNT > 1) ? $clog2(CTX_COUNT) : 1;
	localparam int CB        = COUNTER_BITS;

	typedef struct packed {
		logic [CB-1:0] checks;
		logic [CB-1:0] successes;
		logic [CB-1:0] skips;
		logic [CB-1:0] unaudited;
		logic [CB-1:0] audits;
	} ctx_t;

	localparam int DW = $bits(ctx_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_FAST
	} state_t;

	function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	state_t                state_q;
	cfg_t                  regs;
	logic                  cmd_q;
	logic                  ok_q;
	logic [AW-1:0]         idx_q;
	logic                  out_valid_q;
	logic                  do_check_q;
	logic                  is_audit_q;
	logic [TOTAL_BITS-1:0] sum_checks_q, sum_successes_q, sum_skips_q, sum_audits_q;

	logic          accept;
	logic          in_range;
	logic [AW-1:0] idx_d;
	logic [DW-1:0] rd_data;
	ctx_t          ent;
	ctx_t          ent_new;
	logic          post_done;
	logic          post_pass;
	logic          out_free;
	logic          warm;
	logic          audit_due;
	logic          chk_d;
	logic          aud_d;
	logic          wr_en;
	logic          clr;
	logic          emit;

	acsp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign accept   = req.valid && req.ready;
	assign in_range = 32'(req.gate_family) < FAMILY_COUNT;
	assign idx_d    = AW'(32'(req.gate_family) * WIDTH_BUCKETS
		+ 32'(bucket_of(req.comp_width)));

	acsp_ctx_mem #(
		.DEPTH (CTX_COUNT),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && req.command == CMD_DECIDE && in_range),
		.rd_addr (idx_d),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (DW'(ent_new)),
		.clr     (clr)
	);

	assign ent = ctx_t'(rd_data);

	acsp_post #(
		.CB (CB)
	) u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == ST_READ),
		.succ         (ent.successes),
		.chk          (ent.checks),
		.prior_hits   (regs.prior_hits),
		.prior_misses (regs.prior_misses),
		.thr          (regs.min_posterior),
		.done         (post_done),
		.pass         (post_pass)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign warm      = ent.checks < CB'(regs.warmup_count);
	assign audit_due = (regs.audit_period != '0) && (ent.unaudited >= CB'(regs.audit_period));
	assign chk_d     = !regs.policy_enabled || warm || audit_due || post_pass;
	assign aud_d     = regs.policy_enabled && !warm && audit_due;
	assign wr_en     = (state_q == ST_WAIT) && post_done && out_free;
	assign clr       = (state_q == ST_FAST) && out_free && (cmd_q == CMD_CLEAR);
	assign emit      = wr_en || ((state_q == ST_FAST) && out_free);

	always_comb begin
		ent_new = ent;
		if (chk_d) begin
			ent_new.checks    = bump(ent.checks);
			ent_new.unaudited = '0;
			if (aud_d) begin
				ent_new.audits = bump(ent.audits);
			end
			if (ok_q) begin
				ent_new.successes = bump(ent.successes);
			end
		end else begin
			ent_new.skips     = bump(ent.skips);
			ent_new.unaudited = bump(ent.unaudited);
		end
	end

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.do_check        = do_check_q;
	assign rsp.is_audit        = is_audit_q;
	assign rsp.total_checks    = sum_checks_q;
	assign rsp.total_successes = sum_successes_q;
	assign rsp.total_skips     = sum_skips_q;
	assign rsp.total_audits    = sum_audits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cmd_q           <= CMD_DECIDE;
			ok_q            <= 1'b0;
			idx_q           <= '0;
			out_valid_q     <= 1'b0;
			do_check_q      <= 1'b0;
			is_audit_q      <= 1'b0;
			sum_checks_q    <= '0;
			sum_successes_q <= '0;
			sum_skips_q     <= '0;
			sum_audits_q    <= '0;
		end else begin
			if (rsp.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= req.command;
						ok_q  <= req.compaction_succeeds;
						idx_q <= idx_d;
						if (req.command == CMD_CLEAR || !in_range) begin
							state_q <= ST_FAST;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (post_done && out_free) begin
						out_valid_q <= 1'b1;
						do_check_q  <= chk_d;
						is_audit_q  <= aud_d;
						if (chk_d) begin
							sum_checks_q <= sat_inc_total(sum_checks_q);
							if (aud_d) begin
								sum_audits_q <= sat_inc_total(sum_audits_q);
							end
							if (ok_q) begin
								sum_successes_q <= sat_inc_total(sum_successes_q);
							end
						end else begin
							sum_skips_q <= sat_inc_total(sum_skips_q);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FAST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_audit_q  <= 1'b0;
						if (cmd_q == CMD_CLEAR) begin
							do_check_q      <= 1'b0;
							sum_checks_q    <= '0;
							sum_successes_q <= '0;
							sum_skips_q     <= '0;
							sum_audits_q    <= '0;
						end else begin
							do_check_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/acsp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acsp_cfg_regs (
	input  wire            clk,
	input  wire            arst_n,
	acsp_cfg_if.sink       cfg,
	output acsp_pkg::cfg_t regs
);
	import acsp_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_POLICY_ENABLED: regs_q.policy_enabled <= cfg.data[0];
				REG_WARMUP_COUNT:   regs_q.warmup_count   <= cfg.data[15:0];
				REG_AUDIT_PERIOD:   regs_q.audit_period   <= cfg.data[15:0];
				REG_PRIOR_HITS:     regs_q.prior_hits     <= cfg.data[15:0];
				REG_PRIOR_MISSES:   regs_q.prior_misses   <= cfg.data[15:0];
				REG_MIN_POSTERIOR:  regs_q.min_posterior  <= cfg.data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/acsp_ctx_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acsp_ctx_mem #(
	parameter int DEPTH = 18,
	parameter int AW    = 5,
	parameter int DW    = 160
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           rd_en,
	input  wire  [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  wire           wr_en,
	input  wire  [AW-1:0] wr_addr,
	input  wire  [DW-1:0] wr_data,
	input  wire           clr
);
	logic [DW-1:0]    mem [DEPTH];
	logic [DW-1:0]    data_q;
	logic             hit_q;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;
endmodule
`default_nettype wire

// ===== rtl/acsp_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acsp_post #(
	parameter int CB = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [CB-1:0]                    succ,
	input  wire  [CB-1:0]                    chk,
	input  wire  [15:0]                      prior_hits,
	input  wire  [15:0]                      prior_misses,
	input  wire  [acsp_pkg::THR_BITS-1:0]    thr,
	output logic                             done,
	output logic                             pass
);
	import acsp_pkg::*;

	localparam int SW  = CB + 9;
	localparam int TW  = CB + 10;
	localparam int HB  = (TW + 1) / 2;
	localparam int LPW = HB + THR_BITS;
	localparam int HPW = TW - HB + THR_BITS;
	localparam int RW  = TW + THR_BITS;

	logic [CB-1:0]  fail;
	logic [SW-1:0]  s_s1, s_s2, s_s3;
	logic [TW-1:0]  sum_s1;
	logic [LPW-1:0] plo_s2;
	logic [HPW-1:0] phi_s2;
	logic [RW-1:0]  rhs_s3;
	logic           v_s1, v_s2, v_s3;
	logic           done_q, pass_q;

	assign fail = (chk >= succ) ? chk - succ : '0;

	always_ff @(posedge clk) begin
		s_s1   <= SW'(prior_hits) + SW'({succ, 8'd0});
		sum_s1 <= TW'(prior_hits) + TW'({succ, 8'd0}) + TW'(prior_misses) + TW'({fail, 8'd0});
		s_s2   <= s_s1;
		plo_s2 <= LPW'(sum_s1[HB-1:0]) * LPW'(thr);
		phi_s2 <= HPW'(sum_s1[TW-1:HB]) * HPW'(thr);
		s_s3   <= s_s2;
		rhs_s3 <= (RW'(phi_s2) << HB) + RW'(plo_s2);
		if (v_s3) begin
			pass_q <= RW'({s_s3, 16'd0}) >= rhs_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (start) begin
				done_q <= 1'b0;
			end else if (v_s3) begin
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign pass = pass_q;
endmodule
`default_nettype wire
